// ----- rtl/seek_ahead_disk_scheduler_unit_defines.svh -----
// assertion macros used by the scheduler datapath
`ifndef SEEK_AHEAD_DISK_SCHEDULER_UNIT_DEFINES_SVH
`define SEEK_AHEAD_DISK_SCHEDULER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle
`define SADS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the following cycle
`define SADS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sads_pkg.sv -----
`timescale 1ns / 1ps
package sads_pkg;

    // default sizing
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int DRIVES_DEF      = 8;

    // field widths
    localparam int BPD_W   = 13;
    localparam int RETRY_W = 4;
    localparam int MINOR_W = 4;
    localparam int BLOCK_W = 16;
    localparam int TAG_W   = 8;
    localparam int ACT_W   = 3;
    localparam int ADDR_W  = 16;
    localparam int DRV_NUM_W = 3;
    localparam int DIVR_W  = 4;

    // register reset values and constants
    localparam logic [BPD_W-1:0]   BPD_RESET   = 13'd4872;
    localparam logic [RETRY_W-1:0] RETRY_RESET = 4'd10;
    localparam logic [DIVR_W-1:0]  SECTORS     = 4'd12;
    localparam logic [MINOR_W-1:0] INTERLEAVE_BASE = 4'd7;
    localparam int                 MAX_RESULTS = 10;
    localparam logic [1:0]         FLAG_INIT   = 2'b01;
    localparam logic [1:0]         FLAG_DONE   = 2'b10;

    // divide by three: multiply by ceil(2^17/3), keep the top bits
    localparam logic [BLOCK_W-1:0] DIV3_MUL    = 16'hAAAB;
    localparam int                 DIV3_SHIFT  = 17;

    typedef enum logic [ACT_W-1:0] {
        ACT_SEEK  = 3'd0,
        ACT_START = 3'd1,
        ACT_OK    = 3'd2,
        ACT_ERR   = 3'd3,
        ACT_RESET = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        TAG_ZERO  = 2'd0,
        TAG_INPUT = 2'd1,
        TAG_RAM   = 2'd2,
        TAG_ENTRY = 2'd3
    } t_tag_src;

    typedef enum logic {
        CFG_BPD   = 1'b0,
        CFG_RETRY = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [MINOR_W-1:0] minor;
        logic [BLOCK_W-1:0] block;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic     capture;
        logic     push;
        logic     clr_flags;
        logic     retry_inc;
        logic     set_done;
        logic     rd_head;
        logic     rd_walk;
        logic     claim_ram;
        logic     k_set1;
        logic     k_inc;
        logic     load_ent;
        logic     set_ta;
        logic     div_start;
        logic     save_r1;
        logic     latch_addr;
        logic     pop;
        logic     emit;
        t_action  act;
        t_tag_src tag_src;
        logic     flush;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic opcode;
        logic reject;
        logic error_bit;
        logic seek_done;
        logic ta;
        logic count_zero;
        logic retry_ok;
        logic ready;
        logic head_blocked;
        logic ram_flag_any;
        logic walk_more;
        logic div_done;
    } t_status;

endpackage

// ----- rtl/sads_ram.sv -----
`timescale 1ns / 1ps
module sads_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/sads_div.sv -----
`timescale 1ns / 1ps
module sads_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sads_pkg::BLOCK_W-1:0] i_dividend,
    input  logic [sads_pkg::DIVR_W-1:0]  i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [sads_pkg::BLOCK_W-1:0] o_quotient,
    output logic [sads_pkg::DIVR_W-1:0]  o_remainder
);
    import sads_pkg::*;

    localparam int CNT_W = $clog2(BLOCK_W + 1);

    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [BLOCK_W-1:0] r_q;
    logic [DIVR_W-1:0]  r_rem;
    logic [DIVR_W-1:0]  r_dvs;
    logic [DIVR_W:0]    w_trial;
    logic               w_fit;

    // restoring step, one quotient bit per cycle
    assign w_trial = {r_rem, r_q[BLOCK_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(BLOCK_W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    // quotient shifts in as the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q <= {r_q[BLOCK_W-2:0], w_fit};
            if (w_fit) begin
                r_rem <= DIVR_W'(w_trial - {1'b0, r_dvs});
            end else begin
                r_rem <= w_trial[DIVR_W-1:0];
            end
        end
    end

    assign o_busy      = (r_cnt != '0);
    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;
endmodule

// ----- rtl/sads_ctrl.sv -----
`timescale 1ns / 1ps
module sads_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sads_pkg::t_status i_status,
    output sads_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    import sads_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_HRD, S_HFIN, S_ST, S_SCHK, S_WALK, S_WCHK,
        S_HLD, S_A0, S_A0W, S_A1W, S_EM, S_FIN
    } t_state;

    t_state  r_state, n_state;
    logic    r_busy;
    logic    r_is_head, n_is_head;
    t_action r_pop_act, n_pop_act;
    t_cmd    w_cmd;

    // next state and command decode
    always_comb begin
        n_state   = r_state;
        n_is_head = r_is_head;
        n_pop_act = r_pop_act;
        w_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                if (!i_status.opcode) begin
                    if (i_status.reject) begin
                        w_cmd.emit    = 1'b1;
                        w_cmd.act     = ACT_ERR;
                        w_cmd.tag_src = TAG_INPUT;
                        n_state       = S_FIN;
                    end else begin
                        w_cmd.push = 1'b1;
                        n_state    = i_status.ta ? S_FIN : S_ST;
                    end
                end else if (i_status.error_bit) begin
                    w_cmd.emit      = 1'b1;
                    w_cmd.act       = ACT_RESET;
                    w_cmd.tag_src   = TAG_ZERO;
                    w_cmd.clr_flags = 1'b1;
                    if (i_status.count_zero) begin
                        n_state = S_FIN;
                    end else if (i_status.retry_ok) begin
                        w_cmd.retry_inc = 1'b1;
                        n_state         = S_ST;
                    end else begin
                        n_pop_act = ACT_ERR;
                        n_state   = S_HRD;
                    end
                end else if (i_status.seek_done) begin
                    w_cmd.set_done = 1'b1;
                    n_state        = i_status.ta ? S_FIN : S_ST;
                end else if (!i_status.count_zero && i_status.ta && i_status.ready) begin
                    n_pop_act = ACT_OK;
                    n_state   = S_HRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_HRD: begin
                w_cmd.rd_head = 1'b1;
                n_state       = S_HFIN;
            end
            S_HFIN: begin
                w_cmd.pop     = 1'b1;
                w_cmd.emit    = 1'b1;
                w_cmd.act     = r_pop_act;
                w_cmd.tag_src = TAG_RAM;
                n_state       = S_ST;
            end
            S_ST: begin
                if (i_status.count_zero) begin
                    n_state = S_FIN;
                end else begin
                    w_cmd.rd_head = 1'b1;
                    n_state       = S_SCHK;
                end
            end
            S_SCHK: begin
                if (i_status.head_blocked) begin
                    n_state = S_FIN;
                end else begin
                    w_cmd.claim_ram = 1'b1;
                    w_cmd.k_set1    = 1'b1;
                    n_state         = S_WALK;
                end
            end
            S_WALK: begin
                if (i_status.walk_more) begin
                    w_cmd.rd_walk = 1'b1;
                    n_state       = S_WCHK;
                end else begin
                    w_cmd.rd_head = 1'b1;
                    n_state       = S_HLD;
                end
            end
            S_WCHK: begin
                w_cmd.k_inc = 1'b1;
                if (!i_status.ram_flag_any) begin
                    w_cmd.claim_ram = 1'b1;
                    w_cmd.load_ent  = 1'b1;
                    n_is_head       = 1'b0;
                    n_state         = S_A0;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_HLD: begin
                w_cmd.load_ent = 1'b1;
                w_cmd.set_ta   = 1'b1;
                n_is_head      = 1'b1;
                n_state        = S_A0;
            end
            S_A0: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_A0W;
            end
            S_A0W: begin
                if (i_status.div_done) begin
                    w_cmd.save_r1 = 1'b1;
                    n_state       = S_A1W;
                end
            end
            S_A1W: begin
                w_cmd.latch_addr = 1'b1;
                n_state          = S_EM;
            end
            S_EM: begin
                w_cmd.emit    = 1'b1;
                w_cmd.act     = r_is_head ? ACT_START : ACT_SEEK;
                w_cmd.tag_src = TAG_ENTRY;
                n_state       = r_is_head ? S_FIN : S_WALK;
            end
            S_FIN: begin
                w_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_busy    <= 1'b0;
            r_is_head <= 1'b0;
            r_pop_act <= ACT_OK;
        end else begin
            r_state   <= n_state;
            r_busy    <= (n_state != S_IDLE);
            r_is_head <= n_is_head;
            r_pop_act <= n_pop_act;
        end
    end

    assign o_cmd  = w_cmd;
    assign o_busy = r_busy;
endmodule

// ----- rtl/sads_dpath.sv -----
`timescale 1ns / 1ps
`include "seek_ahead_disk_scheduler_unit_defines.svh"
module sads_dpath #(
    parameter int QUEUE_DEPTH = sads_pkg::QUEUE_DEPTH_DEF,
    parameter int DRIVES      = sads_pkg::DRIVES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sads_pkg::t_cmd                 i_cmd,
    output sads_pkg::t_status              o_status,
    input  logic                           i_opcode,
    input  logic [sads_pkg::MINOR_W-1:0]   i_minor_number,
    input  logic [sads_pkg::BLOCK_W-1:0]   i_block_number,
    input  logic [sads_pkg::TAG_W-1:0]     i_request_tag,
    input  logic                           i_error_bit,
    input  logic                           i_seek_done_bit,
    input  logic [sads_pkg::DRV_NUM_W-1:0] i_seek_drive,
    input  logic                           i_drive_ready,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [sads_pkg::BPD_W-1:0]     i_cfg_data,
    output logic                           o_strobe,
    output logic [sads_pkg::ACT_W-1:0]     o_action,
    output logic [sads_pkg::ADDR_W-1:0]    o_disk_address,
    output logic [sads_pkg::TAG_W-1:0]     o_tag,
    output logic                           o_last
);
    import sads_pkg::*;

    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SW    = CW + 1;
    localparam int DRV_W = (DRIVES > 1) ? $clog2(DRIVES) : 1;
    localparam int ENT_W = $bits(t_entry);
    localparam int EC_W  = $clog2(MAX_RESULTS + 1);
    localparam int PROD_W = (BLOCK_W - 2) + BLOCK_W;

    // queue pointers and drive state
    logic [QW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_k;
    logic [1:0]         r_flags [DRIVES];
    logic               r_ta;
    logic [RETRY_W-1:0] r_err_cnt;
    logic [BPD_W-1:0]   r_bpd;
    logic [RETRY_W-1:0] r_retry;

    // captured request
    logic               r_in_op;
    logic [MINOR_W-1:0] r_in_minor;
    logic [BLOCK_W-1:0] r_in_block;
    logic [TAG_W-1:0]   r_in_tag;
    logic               r_in_err;
    logic               r_in_sdone;
    logic [DRV_NUM_W-1:0] r_in_sdrive;
    logic               r_in_ready;

    // address build
    t_entry             r_ent;
    logic [DRV_NUM_W-1:0] r_drive;
    logic [BLOCK_W-1:0] r_quo1;
    logic [ADDR_W-1:0]  r_addr;

    // result staging
    logic               r_pend_v;
    logic [ACT_W-1:0]   r_pend_act;
    logic [ADDR_W-1:0]  r_pend_addr;
    logic [TAG_W-1:0]   r_pend_tag;
    logic [EC_W-1:0]    r_emit_cnt;
    logic               r_out_strobe;
    logic [ACT_W-1:0]   r_out_act;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [TAG_W-1:0]   r_out_tag;
    logic               r_out_last;

    t_entry             w_rd;
    logic [ENT_W-1:0]   w_rd_raw;
    logic [QW-1:0]      w_raddr;
    logic [QW-1:0]      w_waddr;
    logic [1:0]         w_rd_flag;
    logic [DRV_W-1:0]   w_rd_drv;
    logic [MINOR_W-1:0] w_in_mult;
    logic [MINOR_W-1:0] w_ent_mult;
    logic [BLOCK_W:0]   w_limit;
    logic               w_reject;
    logic [BLOCK_W-1:0] w_div_q;
    logic [DIVR_W-1:0]  w_div_r;
    logic               w_div_busy;
    logic               w_div_done;
    logic [BLOCK_W-1:0] w_div_a;
    logic [DIVR_W-1:0]  w_div_b;
    logic [PROD_W-1:0]  w_prod;
    logic [BLOCK_W-1:0] w_sec_q;
    logic [DIVR_W-1:0]  w_sec_r;
    logic [ADDR_W-1:0]  w_emit_addr;
    logic [TAG_W-1:0]   w_emit_tag;

    // ring index: base plus offset, wrapped once
    function automatic logic [QW-1:0] wrap(input logic [QW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(QUEUE_DEPTH)) begin
            s = s - SW'(QUEUE_DEPTH);
        end
        return s[QW-1:0];
    endfunction

    // request queue storage
    assign w_raddr = i_cmd.rd_head ? r_head : wrap(r_head, r_k);
    assign w_waddr = wrap(r_head, r_count);

    sads_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (w_waddr),
        .i_wdata ({r_in_minor, r_in_block, r_in_tag}),
        .i_re    (i_cmd.rd_head | i_cmd.rd_walk),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_raw)
    );

    assign w_rd      = t_entry'(w_rd_raw);
    assign w_rd_drv  = w_rd.minor[DRV_W-1:0];
    assign w_rd_flag = r_flags[w_rd_drv];

    // admission check
    assign w_in_mult  = (r_in_minor > INTERLEAVE_BASE) ? r_in_minor - INTERLEAVE_BASE
                                                       : MINOR_W'(1);
    assign w_ent_mult = (r_ent.minor > INTERLEAVE_BASE) ? r_ent.minor - INTERLEAVE_BASE
                                                        : MINOR_W'(1);
    assign w_limit    = (BLOCK_W+1)'(r_bpd) * (BLOCK_W+1)'(w_in_mult);
    assign w_reject   = ({1'b0, r_in_block} >= w_limit)
                     || (r_count >= CW'(QUEUE_DEPTH))
                     || ({1'b0, r_in_minor[DRV_NUM_W-1:0]} >= (DRV_NUM_W+1)'(DRIVES));

    // divider: block by interleave count
    assign w_div_a = r_ent.block;
    assign w_div_b = w_ent_mult;

    sads_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_div_a),
        .i_divisor   (w_div_b),
        .o_busy      (w_div_busy),
        .o_done      (w_div_done),
        .o_quotient  (w_div_q),
        .o_remainder (w_div_r)
    );

    // sectors: (b/4)/3 by reciprocal multiply, exact for 14-bit operands
    assign w_prod  = PROD_W'(r_quo1[BLOCK_W-1:2]) * PROD_W'(DIV3_MUL);
    assign w_sec_q = BLOCK_W'(w_prod[PROD_W-1:DIV3_SHIFT]);
    assign w_sec_r = DIVR_W'(r_quo1 - BLOCK_W'(w_sec_q * SECTORS));

    // status to controller
    always_comb begin
        o_status.opcode       = r_in_op;
        o_status.reject       = w_reject;
        o_status.error_bit    = r_in_err;
        o_status.seek_done    = r_in_sdone;
        o_status.ta           = r_ta;
        o_status.count_zero   = (r_count == '0);
        o_status.retry_ok     = ({1'b0, r_err_cnt} + 1'b1) <= {1'b0, r_retry};
        o_status.ready        = r_in_ready;
        o_status.head_blocked = w_rd_flag[0] & ~w_rd_flag[1];
        o_status.ram_flag_any = |w_rd_flag;
        o_status.walk_more    = (r_k < r_count);
        o_status.div_done     = w_div_done;
    end

    // config and queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_k       <= '0;
            r_ta      <= 1'b0;
            r_err_cnt <= '0;
            r_bpd     <= BPD_RESET;
            r_retry   <= RETRY_RESET;
            for (int i = 0; i < DRIVES; i++) begin
                r_flags[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_BPD:   r_bpd   <= i_cfg_data;
                    CFG_RETRY: r_retry <= i_cfg_data[RETRY_W-1:0];
                    default:   r_bpd   <= r_bpd;
                endcase
            end
            if (i_cmd.push) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.clr_flags) begin
                for (int i = 0; i < DRIVES; i++) begin
                    r_flags[i] <= '0;
                end
            end
            if (i_cmd.set_done && ({1'b0, r_in_sdrive} < (DRV_NUM_W+1)'(DRIVES))) begin
                r_flags[r_in_sdrive[DRV_W-1:0]] <= r_flags[r_in_sdrive[DRV_W-1:0]]
                                                   | FLAG_DONE;
            end
            if (i_cmd.retry_inc) begin
                r_err_cnt <= r_err_cnt + 1'b1;
            end
            if (i_cmd.claim_ram) begin
                r_flags[w_rd_drv] <= w_rd_flag | FLAG_INIT;
            end
            if (i_cmd.k_set1) begin
                r_k <= CW'(1);
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.set_ta) begin
                r_ta <= 1'b1;
            end
            if (i_cmd.pop) begin
                r_flags[w_rd_drv] <= '0;
                r_ta      <= 1'b0;
                r_err_cnt <= '0;
                r_head    <= wrap(r_head, CW'(1));
                r_count   <= r_count - 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_op     <= i_opcode;
            r_in_minor  <= i_minor_number;
            r_in_block  <= i_block_number;
            r_in_tag    <= i_request_tag;
            r_in_err    <= i_error_bit;
            r_in_sdone  <= i_seek_done_bit;
            r_in_sdrive <= i_seek_drive;
            r_in_ready  <= i_drive_ready;
        end
        if (i_cmd.load_ent) begin
            r_ent <= w_rd;
        end
        if (i_cmd.save_r1) begin
            r_drive <= (r_ent.minor > INTERLEAVE_BASE) ? w_div_r[DRV_NUM_W-1:0]
                                                       : r_ent.minor[DRV_NUM_W-1:0];
            r_quo1  <= w_div_q;
        end
        if (i_cmd.latch_addr) begin
            r_addr <= {r_drive, 13'd0} | ADDR_W'({w_sec_q, 4'd0}) | ADDR_W'(w_sec_r);
        end
    end

    // result fields
    assign w_emit_addr = (i_cmd.act == ACT_SEEK || i_cmd.act == ACT_START) ? r_addr : '0;
    always_comb begin
        case (i_cmd.tag_src)
            TAG_INPUT: w_emit_tag = r_in_tag;
            TAG_RAM:   w_emit_tag = w_rd.tag;
            TAG_ENTRY: w_emit_tag = r_ent.tag;
            default:   w_emit_tag = '0;
        endcase
    end

    // one result held back so the final one can carry last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v     <= 1'b0;
            r_emit_cnt   <= '0;
            r_out_strobe <= 1'b0;
        end else begin
            r_out_strobe <= 1'b0;
            if (i_cmd.capture) begin
                r_emit_cnt <= '0;
            end
            if (i_cmd.emit && (r_emit_cnt < EC_W'(MAX_RESULTS))) begin
                r_emit_cnt <= r_emit_cnt + 1'b1;
                r_pend_v   <= 1'b1;
                if (r_pend_v) begin
                    r_out_strobe <= 1'b1;
                end
            end
            if (i_cmd.flush && r_pend_v) begin
                r_out_strobe <= 1'b1;
                r_pend_v     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && (r_emit_cnt < EC_W'(MAX_RESULTS))) begin
            r_pend_act  <= i_cmd.act;
            r_pend_addr <= w_emit_addr;
            r_pend_tag  <= w_emit_tag;
            r_out_act   <= r_pend_act;
            r_out_addr  <= r_pend_addr;
            r_out_tag   <= r_pend_tag;
            r_out_last  <= 1'b0;
        end
        if (i_cmd.flush) begin
            r_out_act  <= r_pend_act;
            r_out_addr <= r_pend_addr;
            r_out_tag  <= r_pend_tag;
            r_out_last <= 1'b1;
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_strobe       = r_out_strobe;
    assign o_action       = r_out_act;
    assign o_disk_address = r_out_addr;
    assign o_tag          = r_out_tag;
    assign o_last         = r_out_last;

    // checks
    `SADS_ASSERT_NOW(a_pop_nonempty, i_cmd.pop, r_count != '0, "pop from empty queue")
    `SADS_ASSERT_NOW(a_push_room, i_cmd.push, r_count < CW'(QUEUE_DEPTH), "push into full queue")
    `SADS_ASSERT_NOW(a_div_free, i_cmd.div_start, !w_div_busy, "divider restarted while busy")
    `SADS_ASSERT_NEXT(a_flush_empties, i_cmd.flush, !r_pend_v, "held result left after flush")
endmodule

// ----- rtl/seek_ahead_disk_scheduler_unit.sv -----
`timescale 1ns / 1ps
// Disk request scheduler with overlapped seeks. A request or an interrupt is taken when
// start is high and busy is low; busy drops in the cycle in which the final result of
// that item is on the ports. Results appear on o_action/o_disk_address/o_tag/o_last for
// one cycle each, flagged by o_strobe, and the receiver cannot stall them; at most ten
// per item, with o_last on the final one. Each seek or start result is built by the
// one-bit-per-cycle interleave divider (one 16-step pass per disk address; the sector
// split is a reciprocal multiply), and the queue walk examines each queued request
// through the queue memory's read port, in a read state and then a check state.
// Configuration writes are always accepted (o_cfg_ready is tied high).
module seek_ahead_disk_scheduler_unit #(
    parameter int QUEUE_DEPTH = sads_pkg::QUEUE_DEPTH_DEF,
    parameter int DRIVES      = sads_pkg::DRIVES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_opcode,
    input  logic [sads_pkg::MINOR_W-1:0]   i_minor_number,
    input  logic [sads_pkg::BLOCK_W-1:0]   i_block_number,
    input  logic [sads_pkg::TAG_W-1:0]     i_request_tag,
    input  logic                           i_error_bit,
    input  logic                           i_seek_done_bit,
    input  logic [sads_pkg::DRV_NUM_W-1:0] i_seek_drive,
    input  logic                           i_drive_ready,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [sads_pkg::BPD_W-1:0]     i_cfg_data,
    output logic                           o_strobe,
    output logic [sads_pkg::ACT_W-1:0]     o_action,
    output logic [sads_pkg::ADDR_W-1:0]    o_disk_address,
    output logic [sads_pkg::TAG_W-1:0]     o_tag,
    output logic                           o_last
);
    import sads_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer
    sads_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    // queue, drive flags, address math, result staging
    sads_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .DRIVES      (DRIVES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_opcode        (i_opcode),
        .i_minor_number  (i_minor_number),
        .i_block_number  (i_block_number),
        .i_request_tag   (i_request_tag),
        .i_error_bit     (i_error_bit),
        .i_seek_done_bit (i_seek_done_bit),
        .i_seek_drive    (i_seek_drive),
        .i_drive_ready   (i_drive_ready),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_action        (o_action),
        .o_disk_address  (o_disk_address),
        .o_tag           (o_tag),
        .o_last          (o_last)
    );
endmodule
